// ----- rtl/core/abtp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the alpha blend truecolor pack unit.
// No dependencies; every other file imports this package.
package abtp_pkg;

  localparam int ChanW    = 8;
  localparam int MaxW     = 16;
  localparam int PosW     = 5;
  localparam int WordW    = 32;
  localparam int BgW      = 24;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int Stages   = 6;

  localparam logic [ChanW-1:0] FullAlpha = 8'd255;

  // Reciprocal of 255 scaled by 2^23, rounded up; the estimate is at most one too high.
  localparam logic [16:0] RecipMul   = 17'h08081;
  localparam int          RecipShift = 23;

  localparam logic [CfgIdxW-1:0] RegAlphaEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBackground  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRedMax      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRedPos      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGreenMax    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGreenPos    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBlueMax     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegBluePos     = 3'd7;

  // Load enables of the lane stages; bit names follow stage numbers.
  typedef struct packed {
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } abtp_adv_t;

  // Floor of x / 255 for any x up to 255 * 255, such as a product of two 8-bit values.
  function automatic logic [ChanW-1:0] div255_16(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ----- rtl/core/abtp_if.sv -----
`timescale 1ns / 1ps
// Handshake interfaces for pixel input, pixel output and configuration writes.
// Depends on abtp_pkg for field widths.
interface abtp_pix_in_if import abtp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_in;
  logic [ChanW-1:0] green_in;
  logic [ChanW-1:0] blue_in;
  logic [ChanW-1:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface abtp_pix_out_if import abtp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] pixel_word;

  modport source (output valid, pixel_word, input ready);
  modport sink (input valid, pixel_word, output ready);
endinterface

interface abtp_cfg_if import abtp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/abtp_lane.sv -----
`timescale 1ns / 1ps
// One color channel: blend over background, then scale to the display maximum.
// Five register stages; depends on abtp_pkg.
module abtp_lane import abtp_pkg::*; (
  input  logic             clk_i,
  input  abtp_adv_t        adv_i,
  input  logic [ChanW-1:0] chan_i,
  input  logic [ChanW-1:0] bg_i,
  input  logic [ChanW-1:0] alpha_i,
  input  logic [MaxW-1:0]  max_i,
  output logic [MaxW-1:0]  scaled_o
);

  logic [15:0]        fg_prod_q, bg_prod_q;
  logic [ChanW-1:0]   blend_q;
  logic [23:0]        mul_q, mul2_q;
  logic [16:0]        est_q;
  logic [MaxW-1:0]    scaled_q;
  logic [40:0]        recip_prod;
  logic [ChanW-1:0]   alpha_inv;
  logic [ChanW:0]     blend_sum;
  logic [25:0]        est_times;

  assign alpha_inv  = FullAlpha - alpha_i;
  assign blend_sum  = {1'b0, div255_16(fg_prod_q)} + {1'b0, div255_16(bg_prod_q)};
  assign recip_prod = 41'(mul_q) * 41'(RecipMul);
  assign est_times  = {1'b0, est_q, 8'd0} - 26'(est_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      fg_prod_q <= 16'(chan_i) * 16'(alpha_i);
      bg_prod_q <= 16'(bg_i) * 16'(alpha_inv);
    end
    if (adv_i.s2) begin
      blend_q <= blend_sum[ChanW-1:0];
    end
    if (adv_i.s3) begin
      mul_q <= 24'(blend_q) * 24'(max_i);
    end
    if (adv_i.s4) begin
      est_q  <= recip_prod[RecipShift+16:RecipShift];
      mul2_q <= mul_q;
    end
    if (adv_i.s5) begin
      if (est_times > 26'(mul2_q)) begin
        scaled_q <= MaxW'(est_q - 17'd1);
      end else begin
        scaled_q <= est_q[MaxW-1:0];
      end
    end
  end

  assign scaled_o = scaled_q;

endmodule

// ----- rtl/core/alpha_blend_truecolor_pack_unit.sv -----
`timescale 1ns / 1ps
// Top level of the alpha blend truecolor pack unit: config registers, pipeline control
// and the final pack stage. Depends on abtp_pkg, abtp_if and abtp_lane.
//
//   Port    Role    Payload
//   in_i    sink    red_in, green_in, blue_in, alpha_in
//   out_o   source  pixel_word
//   cfg_i   sink    index, data (always ready)
//
// One pixel is taken per clock unless an output stall has filled every stage. There are six
// register stages: the blend products, the divide by 255, the scale product, the reciprocal
// product, its one-step correction and the pack.
// Reset clears the valid bits and loads the register reset values.
// A stall on the output holds only the stages that are full; empty stages still fill.
module alpha_blend_truecolor_pack_unit import abtp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  abtp_pix_in_if.sink  in_i,
  abtp_pix_out_if.source out_o,
  abtp_cfg_if.sink     cfg_i
);

  logic              alpha_en_q;
  logic [BgW-1:0]    bg_q;
  logic [MaxW-1:0]   red_max_q, green_max_q, blue_max_q;
  logic [PosW-1:0]   red_pos_q, green_pos_q, blue_pos_q;

  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] en;
  abtp_adv_t         adv;
  logic [ChanW-1:0]  alpha;
  logic [MaxW-1:0]   red_s, green_s, blue_s;
  logic [WordW-1:0]  word_d, word_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_en_q  <= 1'b1;
      bg_q        <= '0;
      red_max_q   <= '0;
      red_pos_q   <= '0;
      green_max_q <= '0;
      green_pos_q <= '0;
      blue_max_q  <= '0;
      blue_pos_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegAlphaEnable: alpha_en_q  <= cfg_i.data[0];
        RegBackground:  bg_q        <= cfg_i.data[BgW-1:0];
        RegRedMax:      red_max_q   <= cfg_i.data[MaxW-1:0];
        RegRedPos:      red_pos_q   <= cfg_i.data[PosW-1:0];
        RegGreenMax:    green_max_q <= cfg_i.data[MaxW-1:0];
        RegGreenPos:    green_pos_q <= cfg_i.data[PosW-1:0];
        RegBlueMax:     blue_max_q  <= cfg_i.data[MaxW-1:0];
        RegBluePos:     blue_pos_q  <= cfg_i.data[PosW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    en[Stages-1] = !valid_q[Stages-1] || out_o.ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign adv = abtp_adv_t'(en[Stages-2:0]);
  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_i.valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign alpha = alpha_en_q ? in_i.alpha_in : FullAlpha;

  abtp_lane u_red (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .chan_i   (in_i.red_in),
    .bg_i     (bg_q[7:0]),
    .alpha_i  (alpha),
    .max_i    (red_max_q),
    .scaled_o (red_s)
  );

  abtp_lane u_green (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .chan_i   (in_i.green_in),
    .bg_i     (bg_q[15:8]),
    .alpha_i  (alpha),
    .max_i    (green_max_q),
    .scaled_o (green_s)
  );

  abtp_lane u_blue (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .chan_i   (in_i.blue_in),
    .bg_i     (bg_q[23:16]),
    .alpha_i  (alpha),
    .max_i    (blue_max_q),
    .scaled_o (blue_s)
  );

  assign word_d = (WordW'(red_s) << red_pos_q)
                | (WordW'(green_s) << green_pos_q)
                | (WordW'(blue_s) << blue_pos_q);

  always_ff @(posedge clk_i) begin
    if (en[Stages-1]) begin
      word_q <= word_d;
    end
  end

  assign out_o.valid      = valid_q[Stages-1];
  assign out_o.pixel_word = word_q;

endmodule
